>>> rtl/bpm_pkg.sv
// ----------------------------------------------------------------------------
// bpm_pkg: shared types and constants for the bus poll master
// Item layouts, reply and poll codes, register indexes and default sizes.
// ----------------------------------------------------------------------------
package bpm_pkg;

	// Default sizing
	localparam int NUM_POINTS_DEF = 5;
	localparam int MISS_LIMIT_DEF = 5;

	// Field widths of the item layouts, miss counters and config index
	localparam int TIME_W  = 32;
	localparam int MISS_W  = 3;
	localparam int FAULT_W = 8;
	localparam int ALARM_W = 16;
	localparam int CFG_IDX_W = 1;

	// Register reset values
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd100;
	localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd20;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REPLY_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 1'd1;

	// Reply classification
	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_BAD      = 2'd1;
	localparam logic [1:0] KIND_NO_TOKEN = 2'd2;
	localparam logic [1:0] KIND_TOKEN    = 2'd3;

	// Reply sender type
	localparam logic [1:0] SRC_OTHER = 2'd0;
	localparam logic [1:0] SRC_POINT = 2'd1;
	localparam logic [1:0] SRC_VOICE = 2'd2;

	// What was polled (also the poll request code)
	typedef enum logic [1:0] {
		PK_NONE  = 2'd0,
		PK_POINT = 2'd1,
		PK_VOICE = 2'd2
	} poll_kind_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [1:0]        reply_kind;
		logic [1:0]        reply_source;
		logic [3:0]        reply_node;
		logic [1:0]        reply_alarm;
		logic              update_lock;
	} in_t;

	typedef struct packed {
		logic [1:0]         poll_request;
		logic [3:0]         poll_target;
		logic [FAULT_W-1:0] fault_mask;
		logic [ALARM_W-1:0] alarm_mask;
		logic [3:0]         lost_count;
		logic               any_alarm;
	} out_t;

endpackage

>>> rtl/bus_poll_master_with_retry.sv
// ----------------------------------------------------------------------------
// bus_poll_master_with_retry: token polling master with per-point retry
// Polls help points round robin and the voice unit every third round, tracks
// alarms, misses and lost points from classified replies.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel (in_valid/in_ready/in_data): one service call per item, with
//    the current tick and at most one deframed, classified reply.
//  - out channel (out_valid/out_ready/out_data): exactly one result per item,
//    in order: the poll issued by that call and the updated status masks.
//  - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the reply
//    timeout (index 0) or the poll interval (index 1); always ready. Write it
//    only while no item is in flight.
//  - An accepted item passes the input register, then the result register.
//  - Throughput: one item per cycle while out_ready is high, set by the input
//    register feeding one compare and mask pass into the result register.
//  - When out_ready is low the result register holds and the input register
//    keeps one more item; in_ready then drops until the result is taken.
//  - Reset: idle, point one current, nothing polled, all counts and masks
//    clear, timeout 100 and interval 20 ticks.
// ----------------------------------------------------------------------------
module bus_poll_master_with_retry #(
	parameter int NUM_POINTS = bpm_pkg::NUM_POINTS_DEF,
	parameter int MISS_LIMIT = bpm_pkg::MISS_LIMIT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  bpm_pkg::in_t                       in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output bpm_pkg::out_t                      out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bpm_pkg::TIME_W-1:0]         cfg_data
);
	import bpm_pkg::*;

	localparam int SLOT_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
	localparam logic [4:0] NUM_PT = 5'(NUM_POINTS);
	localparam logic [3:0] LIMIT  = 4'(MISS_LIMIT);

	// Registers
	logic               valid_s1;
	in_t                in_s1;
	logic               out_valid_q;
	out_t               out_q;
	logic [TIME_W-1:0]  timeout_q;
	logic [TIME_W-1:0]  interval_q;
	logic               waiting_q;
	logic [TIME_W-1:0]  mark_q;
	logic [3:0]         cur_pt_q;
	poll_kind_t         pk_q;
	logic [7:0]         round_q;
	logic [1:0]         rmod3_q;
	logic [MISS_W-1:0]  miss_q [NUM_POINTS];
	logic [FAULT_W-1:0] fault_q;
	logic [ALARM_W-1:0] alarm_q;

	// Next-state signals
	logic               advance;
	logic [SLOT_W-1:0]  slot;
	logic               done;
	logic [TIME_W-1:0]  elapsed;
	logic [4:0]         next_pt;
	logic [3:0]         miss_inc;
	logic               miss_we;
	logic [MISS_W-1:0]  miss_wd;
	logic               n_waiting;
	logic [TIME_W-1:0]  n_mark;
	logic [3:0]         n_cur_pt;
	poll_kind_t         n_pk;
	logic [7:0]         n_round;
	logic [1:0]         n_rmod3;
	logic [FAULT_W-1:0] n_fault;
	logic [ALARM_W-1:0] n_alarm;
	out_t               n_out;

	// Handshakes
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Map the current point to its slot, falling back to point one
	always_comb begin
		if (cur_pt_q >= 4'd1 && 5'(cur_pt_q) <= NUM_PT) begin
			slot = SLOT_W'(cur_pt_q - 4'd1);
		end else begin
			slot = '0;
		end
	end

	// Compute the next state and the result for the registered item
	always_comb begin
		n_waiting = waiting_q;
		n_mark    = mark_q;
		n_cur_pt  = cur_pt_q;
		n_pk      = pk_q;
		n_round   = round_q;
		n_rmod3   = rmod3_q;
		n_fault   = fault_q;
		n_alarm   = alarm_q;
		miss_we   = 1'b0;
		miss_wd   = miss_q[slot];
		miss_inc  = 4'(miss_q[slot]) + 4'd1;
		done      = 1'b0;
		next_pt   = 5'(cur_pt_q) + 5'd1;
		n_out     = '0;
		if (waiting_q) begin
			// A token return from the current point or the voice unit ends the wait
			if (in_s1.reply_kind == KIND_TOKEN) begin
				if (in_s1.reply_source == SRC_POINT && in_s1.reply_node == cur_pt_q) begin
					n_alarm[{slot, 1'b0} +: 2] = in_s1.reply_alarm;
					done = 1'b1;
				end
				if (in_s1.reply_source == SRC_VOICE) begin
					done = 1'b1;
				end
			end
			if (done && pk_q == PK_POINT) begin
				miss_we   = 1'b1;
				miss_wd   = '0;
				n_fault[slot] = 1'b0;
				n_mark    = in_s1.now;
				n_waiting = 1'b0;
			end else if (done && pk_q == PK_VOICE) begin
				n_mark    = in_s1.now;
				n_waiting = 1'b0;
			end
			// On timeout end the wait; count a miss for a help point poll
			elapsed = in_s1.now - n_mark;
			if (elapsed > timeout_q) begin
				n_waiting = 1'b0;
				if (pk_q == PK_POINT) begin
					miss_we = 1'b1;
					if (miss_inc >= LIMIT) begin
						miss_wd = MISS_W'(LIMIT);
						n_fault[slot] = 1'b1;
						n_alarm[{slot, 1'b0} +: 2] = 2'b00;
						n_mark = in_s1.now;
					end else begin
						miss_wd = MISS_W'(miss_inc);
					end
				end else if (pk_q == PK_VOICE) begin
					n_mark = in_s1.now;
				end
			end
		end else begin
			// Start a poll once the interval has passed and updates are not locked
			elapsed = in_s1.now - mark_q;
			if (elapsed > interval_q && !in_s1.update_lock) begin
				if (rmod3_q == 2'd1) begin
					n_pk = PK_VOICE;
					n_out.poll_request = PK_VOICE;
				end else begin
					if (next_pt > NUM_PT || next_pt < 5'd1) begin
						next_pt = 5'd1;
					end
					n_cur_pt = next_pt[3:0];
					n_pk     = PK_POINT;
					n_out.poll_request = PK_POINT;
					n_out.poll_target  = next_pt[3:0];
				end
				n_mark    = in_s1.now;
				n_waiting = 1'b1;
				n_round   = round_q + 8'd1;
				n_rmod3   = (round_q == 8'hFF || rmod3_q == 2'd2) ? 2'd0 : rmod3_q + 2'd1;
			end
		end
		// Status outputs from the updated masks
		n_out.fault_mask = n_fault;
		n_out.alarm_mask = n_alarm;
		for (int i = 0; i < NUM_POINTS; i++) begin
			n_out.lost_count = n_out.lost_count + 4'(n_fault[i]);
			n_out.any_alarm  = n_out.any_alarm | n_alarm[2*i];
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= n_out;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			interval_q <= INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REPLY_TIMEOUT: timeout_q  <= cfg_data;
				CFG_POLL_INTERVAL: interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Poll state, advanced once per processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			mark_q    <= '0;
			cur_pt_q  <= 4'd1;
			pk_q      <= PK_NONE;
			round_q   <= '0;
			rmod3_q   <= '0;
			fault_q   <= '0;
			alarm_q   <= '0;
			for (int i = 0; i < NUM_POINTS; i++) begin
				miss_q[i] <= '0;
			end
		end else if (advance) begin
			waiting_q <= n_waiting;
			mark_q    <= n_mark;
			cur_pt_q  <= n_cur_pt;
			pk_q      <= n_pk;
			round_q   <= n_round;
			rmod3_q   <= n_rmod3;
			fault_q   <= n_fault;
			alarm_q   <= n_alarm;
			if (miss_we) begin
				miss_q[slot] <= miss_wd;
			end
		end
	end

	// Checks
	a_target_only_on_point: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.poll_request != PK_POINT |-> out_q.poll_target == 4'd0)
		else $error("poll target set without a help point poll");

	a_lost_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> 5'(out_q.lost_count) <= NUM_PT)
		else $error("lost count exceeds number of points");

	a_wait_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(waiting_q) |-> pk_q != PK_NONE)
		else $error("waiting started with nothing polled");

	a_fault_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(fault_q >> NUM_POINTS) == '0)
		else $error("fault bit set beyond last point");

	a_poll_rate: assert property (@(posedge clk) disable iff (!arst_n)
		advance && n_out.poll_request != PK_NONE |=> waiting_q)
		else $error("poll issued without waiting for a reply");

endmodule
